@@ hw/rtl/rgtt_pkg.sv @@
// ----------------------------------------------------------------------------
// rgtt_pkg
// Types and constants shared by the replay guard track table.
// ----------------------------------------------------------------------------
package rgtt_pkg;

  localparam int WorkerW = 16;
  localparam int KeyW    = 16;
  localparam int StreamW = 4;
  localparam int SeqW    = 64;
  localparam int HashW   = 64;
  localparam int TimeW   = 40;
  localparam int RetW    = 32;

  typedef enum logic [1:0] {
    ACT_VALIDATE     = 2'd0,
    ACT_COMMIT       = 2'd1,
    ACT_PURGE_EXPIRE = 2'd2,
    ACT_PURGE_WORKER = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    VERD_NONE      = 3'd0,
    VERD_DUP_NONCE = 3'd1,
    VERD_DUP_SEQ   = 3'd2,
    VERD_LOWER_SEQ = 3'd3,
    VERD_GAP       = 3'd4
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NSCAN,
    ST_DIFF,
    ST_COMMIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [WorkerW-1:0] worker;
    logic [KeyW-1:0]    key_ident;
    logic [StreamW-1:0] stream;
    logic [SeqW-1:0]    last_seq;
    logic [TimeW-1:0]   updated;
  } slot_ent_t;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [TimeW-1:0] expiry;
  } nonce_ent_t;

endpackage

@@ hw/rtl/rgtt_ram.sv @@
// ----------------------------------------------------------------------------
// rgtt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgtt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/replay_guard_track_table_unit.sv @@
// ----------------------------------------------------------------------------
// replay_guard_track_table_unit
// Anti-replay track table: sequence and nonce checks per (worker, key, stream).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transfer: tuser is the action, tdata the
//   track key, sequence, nonce digest, time and retention. m_axis returns one
//   result per request. cfg_we_i/cfg_wdata_i load max_gap; the user must load
//   it only while idle, the block does not enforce it. Track records live in
//   a TRACKS-deep RAM, nonce FIFOs (circular, per-track head pointer) in a
//   TRACKS*NONCES_PER_TRACK RAM; valid bits, fill counts and heads are flops.
//   The slot scan and the nonce walk each issue one RAM read per cycle:
//     validate      slot scan, then the nonce walk of a known track
//     commit        slot scan, then the track and nonce write
//     purge worker  slot scan
//     purge expired nonce walk of every track
//   One request is in work at a time; a new one is taken while the previous
//   result still waits in the output register.
//   Reset clears all tracks at once (no clearing pass) and sets max_gap to
//   1024. A stalled m_axis holds the result; the unit finishes the next
//   request and waits in its response state until the output frees.
// ----------------------------------------------------------------------------
module replay_guard_track_table_unit
  import rgtt_pkg::*;
#(
  parameter int TRACKS           = 64,
  parameter int NONCES_PER_TRACK = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // cfg: max_gap
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  // tuser: action[1:0]
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [1:0]   s_axis_tuser_i,
  // tdata: worker[15:0], key_ident[31:16], stream_kind[35:32],
  //        seq_number[99:36], nonce_digest[163:100], now_time[203:164],
  //        retention[235:204], zero pad[239:236]
  input  logic [239:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: accepted[0], verdict[3:1], changed[4], evicted[5], zero pad[7:6]
  output logic [7:0]   m_axis_tdata_o
);

  localparam int SlotW  = TRACKS > 1 ? $clog2(TRACKS) : 1;
  localparam int NIdxW  = NONCES_PER_TRACK > 1 ? $clog2(NONCES_PER_TRACK) : 1;
  localparam int FillW  = $clog2(NONCES_PER_TRACK + 1);
  localparam int NDepth = TRACKS * NONCES_PER_TRACK;
  localparam int NAddrW = NDepth > 1 ? $clog2(NDepth) : 1;
  localparam logic [TimeW-1:0] TimeMax = '1;

  function automatic logic [NIdxW-1:0] wrap_pos(logic [NIdxW-1:0] h, logic [FillW-1:0] o);
    logic [FillW:0] s;
    s = (FillW+1)'(h) + (FillW+1)'(o);
    if (s >= (FillW+1)'(NONCES_PER_TRACK)) s = s - (FillW+1)'(NONCES_PER_TRACK);
    return NIdxW'(s);
  endfunction

  function automatic logic [NAddrW-1:0] naddr(logic [SlotW-1:0] t, logic [NIdxW-1:0] p);
    return NAddrW'(t) * NAddrW'(NONCES_PER_TRACK) + NAddrW'(p);
  endfunction

  state_e state_q, state_d;

  action_e            act_q, act_d;
  logic [WorkerW-1:0] wrk_q, wrk_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [StreamW-1:0] strm_q, strm_d;
  logic [SeqW-1:0]    seq_q, seq_d;
  logic [HashW-1:0]   nonce_q, nonce_d;
  logic [TimeW-1:0]   now_q, now_d;
  logic [RetW-1:0]    ret_q, ret_d;

  logic [SlotW:0]     scan_q, scan_d;
  logic               rv_q, rv_d;
  logic [SlotW-1:0]   rslot_q, rslot_d;
  logic               hit_q, hit_d;
  logic [SlotW-1:0]   hit_slot_q, hit_slot_d;
  logic [SeqW-1:0]    last_q, last_d;
  logic               free_f_q, free_f_d;
  logic [SlotW-1:0]   free_slot_q, free_slot_d;
  logic               min_f_q, min_f_d;
  logic [SlotW-1:0]   min_slot_q, min_slot_d;
  logic [TimeW-1:0]   min_upd_q, min_upd_d;

  logic [SlotW-1:0]   cs_q, cs_d;
  logic [FillW-1:0]   idx_q, idx_d;
  logic [FillW-1:0]   keep_q, keep_d;
  logic               nv_q, nv_d;
  logic               dup_q, dup_d;
  logic               chg_q, chg_d;
  logic               ev_q, ev_d;
  logic               le_q, le_d;
  logic               eq_q, eq_d;
  logic [SeqW-1:0]    diff_q, diff_d;

  logic               slot_vld_q [TRACKS];
  logic               slot_vld_d [TRACKS];
  logic [FillW-1:0]   fill_q [TRACKS];
  logic [FillW-1:0]   fill_d [TRACKS];
  logic [NIdxW-1:0]   head_q [TRACKS];
  logic [NIdxW-1:0]   head_d [TRACKS];

  logic               out_vld_q, out_vld_d;
  logic [7:0]         out_q, out_d;
  logic [63:0]        max_gap_q;

  // memory ports
  logic               s_we, s_re;
  logic [SlotW-1:0]   s_waddr, s_raddr;
  slot_ent_t          s_wdata, s_rdata;
  logic               n_we, n_re;
  logic [NAddrW-1:0]  n_waddr, n_raddr;
  nonce_ent_t         n_wdata, n_rdata;

  logic               in_xfer, scan_done, nscan_done, n_issue, out_free;
  logic [SlotW-1:0]   tgt;

  rgtt_ram #(.Width($bits(slot_ent_t)), .Depth(TRACKS)) u_slot_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  rgtt_ram #(.Width($bits(nonce_ent_t)), .Depth(NDepth)) u_nonce_ram (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .re_i(n_re), .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_vld_q || m_axis_tready_i;
  assign scan_done  = (scan_q == (SlotW+1)'(TRACKS)) && !rv_q;
  assign n_issue    = idx_q < fill_q[cs_q];
  assign nscan_done = !n_issue && !nv_q;
  // commit target: existing track, else lowest free slot, else the LRU slot
  assign tgt = hit_q ? hit_slot_q : (free_f_q ? free_slot_q : min_slot_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (action_e'(s_axis_tuser_i) == ACT_PURGE_EXPIRE) ? ST_NSCAN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          unique case (act_q)
            ACT_VALIDATE:     state_d = hit_q ? ST_NSCAN : ST_DIFF;
            ACT_COMMIT:       state_d = ST_COMMIT;
            ACT_PURGE_EXPIRE: state_d = ST_RESP;
            ACT_PURGE_WORKER: state_d = ST_RESP;
            default:          state_d = ST_RESP;
          endcase
        end
      end
      ST_NSCAN: begin
        if (nscan_done) begin
          if (act_q == ACT_VALIDATE) begin
            state_d = ST_DIFF;
          end else if (cs_q == SlotW'(TRACKS - 1)) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_DIFF:   state_d = ST_RESP;
      ST_COMMIT: state_d = ST_RESP;
      ST_RESP:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic [SeqW-1:0]    last;
    logic [TimeW:0]     exp_sum;
    logic [TimeW-1:0]   expiry;
    logic [FillW-1:0]   f;
    logic [NIdxW-1:0]   h, pos;
    logic [2:0]         verd;

    act_d = act_q; wrk_d = wrk_q; key_d = key_q; strm_d = strm_q;
    seq_d = seq_q; nonce_d = nonce_q; now_d = now_q; ret_d = ret_q;
    scan_d = scan_q; rv_d = 1'b0; rslot_d = rslot_q;
    hit_d = hit_q; hit_slot_d = hit_slot_q; last_d = last_q;
    free_f_d = free_f_q; free_slot_d = free_slot_q;
    min_f_d = min_f_q; min_slot_d = min_slot_q; min_upd_d = min_upd_q;
    cs_d = cs_q; idx_d = idx_q; keep_d = keep_q; nv_d = 1'b0;
    dup_d = dup_q; chg_d = chg_q; ev_d = ev_q;
    le_d = le_q; eq_d = eq_q; diff_d = diff_q;
    slot_vld_d = slot_vld_q; fill_d = fill_q; head_d = head_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_d = out_q;
    s_we = 1'b0; s_waddr = tgt; s_wdata = '0;
    s_re = 1'b0; s_raddr = scan_q[SlotW-1:0];
    n_we = 1'b0; n_waddr = '0; n_wdata = '0;
    n_re = 1'b0; n_raddr = naddr(cs_q, wrap_pos(head_q[cs_q], idx_q));
    last = '0; exp_sum = '0; expiry = '0; f = '0; h = '0; pos = '0;
    verd = VERD_NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          act_d   = action_e'(s_axis_tuser_i);
          wrk_d   = s_axis_tdata_i[15:0];
          key_d   = s_axis_tdata_i[31:16];
          strm_d  = s_axis_tdata_i[35:32];
          seq_d   = s_axis_tdata_i[99:36];
          nonce_d = s_axis_tdata_i[163:100];
          now_d   = s_axis_tdata_i[203:164];
          ret_d   = s_axis_tdata_i[235:204];
          scan_d = '0; hit_d = 1'b0; free_f_d = 1'b0; min_f_d = 1'b0;
          cs_d = '0; idx_d = '0; keep_d = '0;
          dup_d = 1'b0; chg_d = 1'b0; ev_d = 1'b0;
        end
      end

      ST_SCAN: begin
        if (scan_q < (SlotW+1)'(TRACKS)) begin
          s_re    = 1'b1;
          rv_d    = 1'b1;
          rslot_d = scan_q[SlotW-1:0];
          scan_d  = scan_q + 1'b1;
        end
        if (rv_q) begin
          if (slot_vld_q[rslot_q]) begin
            if (act_q == ACT_PURGE_WORKER) begin
              if (s_rdata.worker == wrk_q) begin
                slot_vld_d[rslot_q] = 1'b0;
                fill_d[rslot_q]     = '0;
                chg_d               = 1'b1;
              end
            end else begin
              if (s_rdata.worker == wrk_q && s_rdata.key_ident == key_q &&
                  s_rdata.stream == strm_q) begin
                hit_d      = 1'b1;
                hit_slot_d = rslot_q;
                last_d     = s_rdata.last_seq;
              end
              if (!min_f_q || s_rdata.updated < min_upd_q) begin
                min_f_d    = 1'b1;
                min_slot_d = rslot_q;
                min_upd_d  = s_rdata.updated;
              end
            end
          end else if (!free_f_q) begin
            free_f_d    = 1'b1;
            free_slot_d = rslot_q;
          end
        end
        if (scan_done && act_q == ACT_VALIDATE && hit_q) begin
          cs_d = hit_slot_q; idx_d = '0; keep_d = '0;
        end
      end

      ST_NSCAN: begin
        if (n_issue) begin
          n_re  = 1'b1;
          nv_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
        if (nv_q) begin
          if (act_q == ACT_VALIDATE) begin
            if (n_rdata.hash == nonce_q && now_q < n_rdata.expiry) dup_d = 1'b1;
          end else if (n_rdata.expiry <= now_q) begin
            chg_d = 1'b1;
          end else begin
            // compact in place; the write index never passes the read index
            n_we    = 1'b1;
            n_waddr = naddr(cs_q, wrap_pos(head_q[cs_q], keep_q));
            n_wdata = n_rdata;
            keep_d  = keep_q + 1'b1;
          end
        end
        if (nscan_done && act_q != ACT_VALIDATE) begin
          fill_d[cs_q] = keep_q;
          cs_d   = cs_q + 1'b1;
          idx_d  = '0;
          keep_d = '0;
        end
      end

      ST_DIFF: begin
        last   = hit_q ? last_q : '0;
        le_d   = seq_q <= last;
        eq_d   = (seq_q == last) && (last != '0);
        diff_d = seq_q - last;
      end

      ST_COMMIT: begin
        f = hit_q ? fill_q[tgt] : '0;
        h = hit_q ? head_q[tgt] : '0;
        exp_sum = (TimeW+1)'(now_q) + (TimeW+1)'(ret_q);
        expiry  = exp_sum[TimeW] ? TimeMax : exp_sum[TimeW-1:0];
        if (f == FillW'(NONCES_PER_TRACK)) begin
          // full: overwrite the oldest and advance the head
          pos = h;
          head_d[tgt] = wrap_pos(h, FillW'(1));
          fill_d[tgt] = f;
        end else begin
          pos = wrap_pos(h, f);
          head_d[tgt] = h;
          fill_d[tgt] = f + 1'b1;
        end
        slot_vld_d[tgt]  = 1'b1;
        s_we             = 1'b1;
        s_wdata.worker   = wrk_q;
        s_wdata.key_ident = key_q;
        s_wdata.stream   = strm_q;
        s_wdata.last_seq = seq_q;
        s_wdata.updated  = now_q;
        n_we             = 1'b1;
        n_waddr          = naddr(tgt, pos);
        n_wdata.hash     = nonce_q;
        n_wdata.expiry   = expiry;
        chg_d = 1'b1;
        ev_d  = !hit_q && !free_f_q;
      end

      ST_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (act_q == ACT_VALIDATE) begin
            priority if (dup_q)             verd = VERD_DUP_NONCE;
            else if (le_q && eq_q)          verd = VERD_DUP_SEQ;
            else if (le_q)                  verd = VERD_LOWER_SEQ;
            else if (diff_q > max_gap_q)    verd = VERD_GAP;
            else                            verd = VERD_NONE;
            out_d = {2'b00, 1'b0, 1'b0, verd, verd == VERD_NONE};
          end else begin
            out_d = {2'b00, ev_q, chg_q, VERD_NONE, 1'b1};
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      max_gap_q <= 64'd1024;
      rv_q      <= 1'b0;
      nv_q      <= 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
        slot_vld_q[i] <= 1'b0;
        fill_q[i]     <= '0;
        head_q[i]     <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      rv_q      <= rv_d;
      nv_q      <= nv_d;
      if (cfg_we_i) max_gap_q <= cfg_wdata_i;
      slot_vld_q <= slot_vld_d;
      fill_q     <= fill_d;
      head_q     <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; wrk_q <= wrk_d; key_q <= key_d; strm_q <= strm_d;
    seq_q <= seq_d; nonce_q <= nonce_d; now_q <= now_d; ret_q <= ret_d;
    scan_q <= scan_d; rslot_q <= rslot_d;
    hit_q <= hit_d; hit_slot_q <= hit_slot_d; last_q <= last_d;
    free_f_q <= free_f_d; free_slot_q <= free_slot_d;
    min_f_q <= min_f_d; min_slot_q <= min_slot_d; min_upd_q <= min_upd_d;
    cs_q <= cs_d; idx_q <= idx_d; keep_q <= keep_d;
    dup_q <= dup_d; chg_q <= chg_d; ev_q <= ev_d;
    le_q <= le_d; eq_q <= eq_d; diff_q <= diff_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NSCAN |-> fill_q[cs_q] <= FillW'(NONCES_PER_TRACK))
    else $error("nonce fill above capacity");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT |=> slot_vld_q[$past(tgt)])
    else $error("committed slot not valid");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside response state");

  a_evict_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q[5] |-> out_q[4])
    else $error("eviction reported without change");
`endif

endmodule
